/* rtl/ph_cal_pkg.sv */
package ph_cal_pkg;

    // fixed result format: unsigned Q4.12 pH
    localparam int PH_W   = 16;
    localparam int Q_FRAC = 12;

    // quotient width of the shared divider (covers both divisions)
    localparam int QUO_W = 16;

    // calibration points and segments
    localparam int NUM_CAL   = 5;
    localparam int NUM_SEG   = 4;
    localparam int SEG_W     = 2;
    localparam int CFG_IDX_W = 3;

    localparam int DEFAULT_WINDOW_LEN = 10;
    localparam int DEFAULT_ADC_BITS   = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PH14 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PH10 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PH7  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PH4  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PH0  = 3'd4;

    // reset values of the calibration codes
    localparam int unsigned CAL_RESET [NUM_CAL] = '{500, 1300, 2048, 2700, 3500};

    // segment codes
    localparam logic [SEG_W-1:0] SEG_PH14_10 = 2'd0;
    localparam logic [SEG_W-1:0] SEG_PH10_7  = 2'd1;
    localparam logic [SEG_W-1:0] SEG_PH7_4   = 2'd2;
    localparam logic [SEG_W-1:0] SEG_PH4_0   = 2'd3;

    // pH at the start of a segment, Q4.12
    function automatic logic [PH_W-1:0] seg_ph_start(input logic [SEG_W-1:0] seg);
        logic [PH_W-1:0] ph;
        case (seg)
            SEG_PH14_10: ph = PH_W'(14 << Q_FRAC);
            SEG_PH10_7:  ph = PH_W'(10 << Q_FRAC);
            SEG_PH7_4:   ph = PH_W'(7 << Q_FRAC);
            SEG_PH4_0:   ph = PH_W'(4 << Q_FRAC);
            default:     ph = '0;
        endcase
        return ph;
    endfunction

    // pH drop across a segment, whole units
    function automatic logic [2:0] seg_ph_drop(input logic [SEG_W-1:0] seg);
        logic [2:0] drop;
        case (seg)
            SEG_PH14_10: drop = 3'd4;
            SEG_PH10_7:  drop = 3'd3;
            SEG_PH7_4:   drop = 3'd3;
            SEG_PH4_0:   drop = 3'd4;
            default:     drop = '0;
        endcase
        return drop;
    endfunction

endpackage

/* rtl/ph_cal_regs.sv */
module ph_cal_regs #(
    parameter int ADC_BITS = ph_cal_pkg::DEFAULT_ADC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ph_cal_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ADC_BITS-1:0]                 i_cfg_data,
    output logic [ADC_BITS-1:0]                 o_codes [ph_cal_pkg::NUM_CAL]
);
    import ph_cal_pkg::*;

    logic [ADC_BITS-1:0] r_codes [NUM_CAL];

    // calibration code registers, writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CAL; i++) begin
                r_codes[i] <= ADC_BITS'(CAL_RESET[i]);
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CAL_PH14: r_codes[0] <= i_cfg_data;
                REG_CAL_PH10: r_codes[1] <= i_cfg_data;
                REG_CAL_PH7:  r_codes[2] <= i_cfg_data;
                REG_CAL_PH4:  r_codes[3] <= i_cfg_data;
                REG_CAL_PH0:  r_codes[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_codes     = r_codes;

endmodule

/* rtl/ph_cal_div.sv */
module ph_cal_div #(
    parameter int DVD_W = ph_cal_pkg::DEFAULT_ADC_BITS + 3 + ph_cal_pkg::Q_FRAC,
    parameter int DVS_W = ph_cal_pkg::DEFAULT_ADC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [DVD_W-1:0]               i_dividend,
    input  logic [DVS_W-1:0]               i_divisor,
    output logic                           o_done,
    output logic [ph_cal_pkg::QUO_W-1:0]   o_quotient
);
    import ph_cal_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic [DVS_W-1:0] r_rem;
    logic [QUO_W-1:0] r_lo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_sub;
    logic             fits;
    logic [DVS_W-1:0] n_rem;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial     = {r_rem, r_lo[QUO_W-1]};
        trial_sub = trial - {1'b0, r_dvs};
        fits      = (trial >= {1'b0, r_dvs});
        n_rem     = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    // step sequencer, the quotient bits replace the dividend bits in r_lo
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= DVS_W'(i_dividend >> QUO_W);
                r_lo   <= i_dividend[QUO_W-1:0];
                r_dvs  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_lo  <= {r_lo[QUO_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_lo;

endmodule

/* rtl/ph_calibrate_trimmed_mean_top.sv */
// pH calibration with trimmed mean. Each accepted ADC word is placed in one of four
// calibration segments (pH 14-10, 10-7, 7-4, 4-0, the later segment winning at a shared
// boundary) and interpolated to an unsigned Q4.12 pH; a sample outside every segment
// repeats the previous pH. Results go into a WINDOW_LEN-entry window; the word that
// fills it drops the first maximum and first minimum and averages the nonzero rest,
// rounded, flagging an empty window and keeping the old average in that case. One
// 16-step restoring divider does both divisions. An accepted word goes through segment
// select, the 16 divider steps when it needs interpolation, window write and output
// load; the word that closes the window also runs the max/min scan and the sum pass,
// one entry per cycle each, then the averaging division. The input stalls from
// acceptance until the result is loaded into the output register; a result waiting
// on a stalled output does not block the next acceptance.
module ph_calibrate_trimmed_mean_top #(
    parameter int WINDOW_LEN = ph_cal_pkg::DEFAULT_WINDOW_LEN,
    parameter int ADC_BITS   = ph_cal_pkg::DEFAULT_ADC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ADC_BITS-1:0]                 i_adc_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ph_cal_pkg::PH_W-1:0]         o_ph_now,
    output logic [ph_cal_pkg::PH_W-1:0]         o_ph_average,
    output logic                                o_average_updated,
    output logic                                o_average_empty,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ph_cal_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ADC_BITS-1:0]                 i_cfg_data
);
    import ph_cal_pkg::*;

    localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = PH_W + $clog2(WINDOW_LEN);
    localparam int PRD_W = ADC_BITS + 3;
    localparam int NUM_W = PRD_W + Q_FRAC;
    localparam int DVD_W = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int DVS_W = (ADC_BITS > CNT_W) ? ADC_BITS : CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEG,
        S_INTERP_DIV,
        S_WRITE,
        S_SCAN,
        S_SUM,
        S_AVG_START,
        S_AVG_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    logic [ADC_BITS-1:0] codes [NUM_CAL];

    logic [ADC_BITS-1:0] r_x;
    logic [SEG_W-1:0]    r_seg;
    logic [PH_W-1:0]     r_last_ph;
    logic [PH_W-1:0]     r_held_avg;
    logic [IDX_W-1:0]    r_fill;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_imax;
    logic [IDX_W-1:0]    r_imin;
    logic [PH_W-1:0]     r_max;
    logic [PH_W-1:0]     r_min;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic                r_upd;
    logic                r_empty;
    logic                r_out_valid;
    logic [PH_W-1:0]     r_out_ph_now;
    logic [PH_W-1:0]     r_out_avg;
    logic                r_out_upd;
    logic                r_out_empty;
    logic [PH_W-1:0]     r_window [WINDOW_LEN];

    logic                seg_hit;
    logic [SEG_W-1:0]    seg_sel;
    logic [ADC_BITS-1:0] seg_lo;
    logic [ADC_BITS-1:0] seg_hi;
    logic [ADC_BITS-1:0] seg_span;
    logic [ADC_BITS-1:0] seg_off;
    logic [PRD_W-1:0]    seg_prod;
    logic [DVD_W-1:0]    interp_num;
    logic [PH_W-1:0]     win_rd;
    logic                win_keep;
    logic                idx_last;
    logic                div_start;
    logic [DVD_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    logic                div_done;
    logic [QUO_W-1:0]    div_quotient;

    ph_cal_regs #(
        .ADC_BITS (ADC_BITS)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_codes     (codes)
    );

    ph_cal_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // segment select, the last matching segment wins
    always_comb begin
        seg_hit = 1'b0;
        seg_sel = '0;
        seg_lo  = '0;
        seg_hi  = '0;
        for (int s = 0; s < NUM_SEG; s++) begin
            if (r_x >= codes[s] && r_x <= codes[s+1]) begin
                seg_hit = 1'b1;
                seg_sel = SEG_W'(s);
                seg_lo  = codes[s];
                seg_hi  = codes[s+1];
            end
        end
        seg_span   = seg_hi - seg_lo;
        seg_off    = r_x - seg_lo;
        seg_prod   = PRD_W'(seg_off) * PRD_W'(seg_ph_drop(seg_sel));
        interp_num = DVD_W'({seg_prod, {Q_FRAC{1'b0}}}) + DVD_W'(seg_span >> 1);
    end

    // window read port and trim/sum qualifiers
    always_comb begin
        win_rd   = r_window[r_idx];
        idx_last = (r_idx == IDX_W'(WINDOW_LEN - 1));
        win_keep = (r_idx != r_imax) && (r_idx != r_imin) && (win_rd != '0);
    end

    // shared divider request: interpolation or average
    always_comb begin
        div_start = ((r_state == S_SEG) && seg_hit && (seg_span != '0)) ||
                    ((r_state == S_AVG_START) && (r_count != '0));
        if (r_state == S_SEG) begin
            div_dividend = interp_num;
            div_divisor  = DVS_W'(seg_span);
        end else begin
            div_dividend = DVD_W'(r_sum) + DVD_W'(r_count >> 1);
            div_divisor  = DVS_W'(r_count);
        end
    end

    // window storage
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_window[r_fill] <= r_last_ph;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_ph   <= '0;
            r_held_avg  <= '0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_upd       <= 1'b0;
            r_empty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output word taken, unless the next one is loaded right away
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_adc_sample;
                        r_upd   <= 1'b0;
                        r_empty <= 1'b0;
                        r_state <= S_SEG;
                    end
                end
                S_SEG: begin
                    if (!seg_hit) begin
                        r_state <= S_WRITE;
                    end else if (seg_span == '0) begin
                        r_last_ph <= seg_ph_start(seg_sel);
                        r_state   <= S_WRITE;
                    end else begin
                        r_seg   <= seg_sel;
                        r_state <= S_INTERP_DIV;
                    end
                end
                S_INTERP_DIV: begin
                    if (div_done) begin
                        r_last_ph <= seg_ph_start(r_seg) - PH_W'(div_quotient);
                        r_state   <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_fill == IDX_W'(WINDOW_LEN - 1)) begin
                        r_fill  <= '0;
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_fill  <= r_fill + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    // first maximum and first minimum
                    if (r_idx == '0 || win_rd > r_max) begin
                        r_max  <= win_rd;
                        r_imax <= r_idx;
                    end
                    if (r_idx == '0 || win_rd < r_min) begin
                        r_min  <= win_rd;
                        r_imin <= r_idx;
                    end
                    if (idx_last) begin
                        r_idx   <= '0;
                        r_sum   <= '0;
                        r_count <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SUM: begin
                    if (win_keep) begin
                        r_sum   <= r_sum + SUM_W'(win_rd);
                        r_count <= r_count + 1'b1;
                    end
                    if (idx_last) begin
                        r_state <= S_AVG_START;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_AVG_START: begin
                    r_upd <= 1'b1;
                    if (r_count == '0) begin
                        r_empty <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_AVG_DIV;
                    end
                end
                S_AVG_DIV: begin
                    if (div_done) begin
                        r_held_avg <= PH_W'(div_quotient);
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_ph_now <= r_last_ph;
                        r_out_avg    <= r_held_avg;
                        r_out_upd    <= r_upd;
                        r_out_empty  <= r_empty;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_ph_now          = r_out_ph_now;
    assign o_ph_average      = r_out_avg;
    assign o_average_updated = r_out_upd;
    assign o_average_empty   = r_out_empty;

    // an accepted word always starts with segment select
    a_accept_to_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SEG))
        else $error("accepted word did not enter segment select");

    // divider only finishes while the sequencer waits for it
    a_div_done_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_INTERP_DIV || r_state == S_AVG_DIV))
        else $error("divider finished with no waiting state");

    // empty flag only comes with a completed window
    a_empty_needs_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_average_empty) |-> o_average_updated)
        else $error("empty flag without window completion");

    // window fill pointer stays inside the window
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= IDX_W'(WINDOW_LEN - 1))
        else $error("window fill pointer out of range");

endmodule

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ph_cal_pkg::*;

    // one result word of the block
    typedef struct packed {
        logic [PH_W-1:0] ph_now;
        logic [PH_W-1:0] ph_average;
        logic            updated;
        logic            empty;
    } t_ph_result;

    // calibration and trimmed-mean predictor with the queue of expected result words
    class ph_scoreboard;
        logic [DEFAULT_ADC_BITS-1:0] cal_code [NUM_CAL];
        int unsigned                 ph_point [NUM_CAL];
        logic [PH_W-1:0]             last_ph;
        logic [PH_W-1:0]             ph_win [DEFAULT_WINDOW_LEN];
        int unsigned                 win_fill;
        logic [PH_W-1:0]             held_avg;
        t_ph_result                  expected_q [$];
        int                          mismatches;

        function new();
            ph_point = '{14, 10, 7, 4, 0};
            for (int i = 0; i < NUM_CAL; i++) begin
                cal_code[i] = DEFAULT_ADC_BITS'(CAL_RESET[i]);
            end
            foreach (ph_win[i]) begin
                ph_win[i] = '0;
            end
            last_ph    = '0;
            win_fill   = 0;
            held_avg   = '0;
            mismatches = 0;
        endfunction

        // out-of-range indexes are dropped by the block
        function void note_config(logic [CFG_IDX_W-1:0] idx,
                                  logic [DEFAULT_ADC_BITS-1:0] data);
            if (idx < NUM_CAL) begin
                cal_code[idx] = data;
            end
        endfunction

        // predict the result word of one accepted sample
        function void note_sample(logic [DEFAULT_ADC_BITS-1:0] x);
            t_ph_result  r;
            int unsigned xi;
            int unsigned ca;
            int unsigned cb;
            int unsigned span;
            int unsigned num;
            int unsigned sum;
            int unsigned cnt;
            int          imax;
            int          imin;
            xi = x;
            // segments tried from pH 14 down, the last match wins
            for (int s = 0; s < NUM_SEG; s++) begin
                ca = cal_code[s];
                cb = cal_code[s + 1];
                if (xi >= ca && xi <= cb) begin
                    span = cb - ca;
                    if (span == 0) begin
                        last_ph = PH_W'(ph_point[s] << Q_FRAC);
                    end else begin
                        num = ((ph_point[s] - ph_point[s + 1]) * (xi - ca)) << Q_FRAC;
                        last_ph = PH_W'((ph_point[s] << Q_FRAC) - (num + span / 2) / span);
                    end
                end
            end
            r.updated = 1'b0;
            r.empty   = 1'b0;
            if (win_fill < DEFAULT_WINDOW_LEN) begin
                ph_win[win_fill] = last_ph;
            end
            win_fill++;
            // full window: drop first max and first min, average the nonzero rest
            if (win_fill >= DEFAULT_WINDOW_LEN) begin
                win_fill = 0;
                imax = 0;
                imin = 0;
                for (int i = 0; i < DEFAULT_WINDOW_LEN; i++) begin
                    if (ph_win[i] > ph_win[imax]) imax = i;
                    if (ph_win[i] < ph_win[imin]) imin = i;
                end
                ph_win[imax] = '0;
                ph_win[imin] = '0;
                sum = 0;
                cnt = 0;
                for (int i = 0; i < DEFAULT_WINDOW_LEN; i++) begin
                    if (ph_win[i] != 0) begin
                        sum += ph_win[i];
                        cnt++;
                    end
                end
                r.updated = 1'b1;
                if (cnt == 0) begin
                    r.empty = 1'b1;
                end else begin
                    held_avg = PH_W'((sum + cnt / 2) / cnt);
                end
            end
            r.ph_now     = last_ph;
            r.ph_average = held_avg;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        // compare one output word against the oldest prediction
        task check_result(t_ph_result got);
            t_ph_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result word with nothing pending, ph_now=%0d", got.ph_now));
                return;
            end
            want = expected_q.pop_front();
            if (got.ph_now !== want.ph_now)
                report($sformatf("ph_now got %0d want %0d", got.ph_now, want.ph_now));
            if (got.ph_average !== want.ph_average)
                report($sformatf("ph_average got %0d want %0d",
                                 got.ph_average, want.ph_average));
            if (got.updated !== want.updated)
                report($sformatf("average_updated got %0b want %0b",
                                 got.updated, want.updated));
            if (got.empty !== want.empty)
                report($sformatf("average_empty got %0b want %0b", got.empty, want.empty));
        endtask
    endclass

    localparam int ADC_W         = DEFAULT_ADC_BITS;
    localparam int SETTLE_CYCLES = 2 * DEFAULT_WINDOW_LEN + 40;
    localparam int IDLE_LIMIT    = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 90;
    localparam int NUM_PHASES    = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [ADC_W-1:0]     i_adc_sample;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [PH_W-1:0]      o_ph_now;
    logic [PH_W-1:0]      o_ph_average;
    logic                 o_average_updated;
    logic                 o_average_empty;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ADC_W-1:0]     i_cfg_data;

    ph_scoreboard sb;
    t_ph_result   got_word;
    bit           hold_req = 1'b0;
    int           idle_cycles = 0;

    ph_calibrate_trimmed_mean_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_adc_sample      (i_adc_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_ph_now          (o_ph_now),
        .o_ph_average      (o_ph_average),
        .o_average_updated (o_average_updated),
        .o_average_empty   (o_average_empty),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_word.ph_now     = o_ph_now;
            got_word.ph_average = o_ph_average;
            got_word.updated    = o_average_updated;
            got_word.empty      = o_average_empty;
            sb.check_result(got_word);
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("ph_calibrate_trimmed_mean_top test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output stall pattern, with one long hold-off on request
    initial begin : rx_stall
        int seg_len;
        int mode;
        i_out_stall = 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(1, 60);
            repeat (seg_len) begin
                @(negedge i_clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 1) == 0);
                    default: i_out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // drive one sample word and wait until it is taken
    task automatic send_sample(logic [ADC_W-1:0] x);
        i_in_valid   <= 1'b1;
        i_adc_sample <= x;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(x);
        @(negedge i_clk);
    endtask

    // one register write word; the caller lowers valid after the batch
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADC_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(idx, data);
        @(negedge i_clk);
    endtask

    task automatic wait_results();
        while (sb.expected_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // samples aimed at and around the calibration points, else anywhere
    function automatic logic [ADC_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r < 2) return sb.cal_code[$urandom_range(0, NUM_CAL - 1)];
        if (r == 2) return ADC_W'(sb.cal_code[$urandom_range(0, NUM_CAL - 1)]
                                  + ($urandom_range(0, 1) ? 1 : -1));
        return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
    endfunction

    // calibration set of one phase
    task automatic apply_phase(int p);
        logic [ADC_W-1:0] codes [NUM_CAL];
        int unsigned      acc;
        int unsigned      step;
        case (p)
            1: codes = '{12'd0, 12'd1000, 12'd2000, 12'd3000, 12'd4095};
            2: foreach (codes[i]) codes[i] = '0;
            3: foreach (codes[i]) codes[i] = '1;
            4, 6: begin
                acc = $urandom_range(0, 400);
                foreach (codes[i]) begin
                    if (i > 0) begin
                        // repeated codes give zero-width segments
                        if (p == 6 && $urandom_range(0, 1)) step = 0;
                        else step = $urandom_range(1, 1000);
                        acc = acc + step;
                        if (acc > 4095) acc = 4095;
                    end
                    codes[i] = ADC_W'(acc);
                end
            end
            5: foreach (codes[i]) codes[i] = ADC_W'($urandom);
            default: codes = '{12'd4095, 12'd3000, 12'd2000, 12'd1000, 12'd0};
        endcase
        write_reg(REG_CAL_PH14, codes[0]);
        write_reg(REG_CAL_PH10, codes[1]);
        write_reg(REG_CAL_PH7,  codes[2]);
        write_reg(REG_CAL_PH4,  codes[3]);
        write_reg(REG_CAL_PH0,  codes[4]);
        // indexes past the register list must be ignored
        if (p == 5) begin
            for (int k = 1; k <= 3; k++) begin
                write_reg(CFG_IDX_W'(REG_CAL_PH0 + k), ADC_W'($urandom));
            end
        end
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // random samples in bursts with gaps; optional drain pause and output hold-off
    task automatic run_random(int n, int pause_at, int hold_at);
        int left;
        int burst;
        int gap;
        int r;
        int sent;
        left = n;
        sent = 0;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            if (burst > left) burst = left;
            repeat (burst) begin
                if (sent == pause_at) begin
                    i_in_valid <= 1'b0;
                    @(negedge i_clk);
                    wait_results();
                end
                if (sent == hold_at) hold_req = 1'b1;
                send_sample(pick_sample());
                sent++;
            end
            left -= burst;
            r = $urandom_range(0, 9);
            if (r < 3) gap = 0;
            else if (r < 9) gap = $urandom_range(1, 8);
            else gap = $urandom_range(20, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [ADC_W-1:0] mixed_words [10];
        sb = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_adc_sample = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: range ends, outside samples, shared boundaries, segment ends
        mixed_words = '{12'd0, 12'd4095, 12'd500, 12'd1300, 12'd2048,
                        12'd2700, 12'd3500, 12'd499, 12'd900, 12'd3501};
        foreach (mixed_words[i]) send_sample(mixed_words[i]);
        // window of equal entries
        repeat (DEFAULT_WINDOW_LEN) send_sample(12'd2048);
        // window of pH 0 entries, nothing left after trimming
        repeat (DEFAULT_WINDOW_LEN) send_sample(12'd3500);
        i_in_valid <= 1'b0;
        @(negedge i_clk);

        // random phases, each under its own calibration set
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                settle();
                apply_phase(p);
            end
            run_random(PHASE_ITEMS, (p == 3) ? PHASE_ITEMS / 2 : -1, (p == 1) ? 30 : -1);
        end

        settle();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("ph_calibrate_trimmed_mean_top test passed");
        end else begin
            $display("ph_calibrate_trimmed_mean_top test failed");
        end
        $finish;
    end
endmodule
